// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the checker file of this block.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held low
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is held low
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

// ----- rtl/core/snfcs_pkg.sv -----
// Shared types and constants of the SPI NOR flash command sequencer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package snfcs_pkg;

  // Default page size and depth of the job queue
  localparam int PAGE_BYTES_DEF = 256;
  localparam int QUEUE_DEPTH    = 4;

  // Flash opcodes and filler
  localparam logic [7:0] OP_WREN   = 8'h06;
  localparam logic [7:0] OP_SE     = 8'h20;
  localparam logic [7:0] OP_PP     = 8'h02;
  localparam logic [7:0] OP_READ   = 8'h03;
  localparam logic [7:0] OP_RDSR   = 8'h05;
  localparam logic [7:0] FILL_BYTE = 8'hFF;
  localparam int         BUSY_BIT  = 0;

  // Request commands
  localparam logic [1:0] CMD_ERASE = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_REPLY = 2'd3;

  // Job kinds handed from the front to the back
  localparam logic [2:0] JOB_ERASE     = 3'd0;
  localparam logic [2:0] JOB_WRITE_HDR = 3'd1;
  localparam logic [2:0] JOB_WRITE     = 3'd2;
  localparam logic [2:0] JOB_READ_HDR  = 3'd3;
  localparam logic [2:0] JOB_FILL      = 3'd4;
  localparam logic [2:0] JOB_REJECT    = 3'd5;
  localparam logic [2:0] JOB_DONE      = 3'd6;
  localparam logic [2:0] JOB_RDATA     = 3'd7;

  // Step of a program sequence that carries the data byte
  localparam logic [2:0] STEP_DATA = 3'd5;

  // Stream widths
  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [23:0] addr;
    logic [7:0]  data;
    logic        flag;   // frame end on the data byte, or last read reply
  } job_t;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       spi_valid;
    logic       frame_end;
    logic       reply_wanted;
    logic [7:0] read_data;
    logic       read_valid;
    logic       done_res;
    logic       rejected;
    logic       last_result;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/snfcs_front.sv -----
// Front end: accepts requests, works out the page offset, tracks flash phase
// and turns each request, but an unsolicited reply, into a job. Depends on snfcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module snfcs_front #(
  parameter int PAGE_BYTES = snfcs_pkg::PAGE_BYTES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [snfcs_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic [snfcs_pkg::IN_USER_W-1:0]  in_tuser,
  input  wire logic                             in_tlast,
  output logic                                  job_valid,
  input  wire logic                             job_ready,
  output snfcs_pkg::job_t                       job
);

  localparam int RW    = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
  localparam int SHIFT = 36;
  // Reciprocal of the page size, exact quotient for any 24-bit address
  localparam logic [36:0] MULT =
    37'(((64'd1 << SHIFT) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES));
  localparam logic [17:0] MULT_LO = MULT[17:0];
  localparam logic [18:0] MULT_HI = MULT[36:18];
  localparam logic [RW:0] PAGE_W  = (RW + 1)'(PAGE_BYTES);

  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_WRITE      = 3'd1;
  localparam logic [2:0] PH_READ       = 3'd2;
  localparam logic [2:0] PH_RWAIT      = 3'd3;
  localparam logic [2:0] PH_RWAIT_LAST = 3'd4;
  localparam logic [2:0] PH_POLL       = 3'd5;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [23:0] addr;
    logic [7:0]  data;
    logic        first;
    logic        last;
  } req_t;

  // Offset pipeline registers
  logic        s1_v_r, s2_v_r, s3_v_r;
  req_t        s1_req_r, s2_req_r, s3_req_r;
  logic [41:0] s1_plo_r;
  logic [42:0] s1_phi_r;
  logic [23:0] s2_quot_r;
  logic [36:0] s3_prod_r;
  logic [60:0] s2_sum;
  logic [23:0] s3_diff;
  logic [RW-1:0] s3_rem;

  // Flash state
  logic [2:0]    phase_r, phase_nxt;
  logic [23:0]   cur_addr_r, cur_addr_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic          page_open_r, page_open_nxt;
  logic          run_active_r, run_active_nxt;

  logic   push, s3_take, adv;
  req_t   in_req;
  snfcs_pkg::job_t job_c;

  // Program path: base address, offset and frame end of the next data byte
  logic          wb_start;
  logic [23:0]   wb_base, wb_next;
  logic [RW-1:0] wb_rem, wb_nrem;
  logic [RW:0]   wb_inc;
  logic          wb_popen, wb_end;

  assign in_req.cmd   = in_tuser[1:0];
  assign in_req.first = in_tuser[2];
  assign in_req.addr  = in_tdata[23:0];
  assign in_req.data  = in_tdata[31:24];
  assign in_req.last  = in_tlast;

  assign s3_take   = s3_v_r && (!push || job_ready);
  assign adv       = !s3_v_r || s3_take;
  assign in_tready = adv;
  assign job_valid = s3_v_r && push;
  assign job       = job_c;

  // Page offset of the request address: quotient by reciprocal, then remainder
  assign s2_sum  = 61'(s1_plo_r) + (61'(s1_phi_r) << 18);
  assign s3_diff = s3_req_r.addr - s3_prod_r[23:0];
  assign s3_rem  = s3_diff[RW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_tvalid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_req_r  <= in_req;
      s1_plo_r  <= 42'(in_req.addr) * 42'(MULT_LO);
      s1_phi_r  <= 43'(in_req.addr) * 43'(MULT_HI);
      s2_req_r  <= s1_req_r;
      s2_quot_r <= s2_sum[59:36];
      s3_req_r  <= s2_req_r;
      s3_prod_r <= 37'(s2_quot_r) * 37'(PAGE_BYTES);
    end
  end

  // Next data byte of a program run; a fresh run starts at the request address
  assign wb_start = (phase_r != PH_WRITE);
  assign wb_base  = wb_start ? s3_req_r.addr : cur_addr_r;
  assign wb_rem   = wb_start ? s3_rem : rem_r;
  assign wb_popen = wb_start ? 1'b0 : page_open_r;
  assign wb_next  = wb_base + 24'd1;
  assign wb_inc   = {1'b0, wb_rem} + {{RW{1'b0}}, 1'b1};
  assign wb_nrem  = ((wb_next == 24'd0) || (wb_inc == PAGE_W)) ? '0 : wb_inc[RW-1:0];
  assign wb_end   = s3_req_r.last || (wb_nrem == '0);

  // Classification and phase update
  always_comb begin
    phase_nxt      = phase_r;
    cur_addr_nxt   = cur_addr_r;
    rem_nxt        = rem_r;
    page_open_nxt  = page_open_r;
    run_active_nxt = run_active_r;
    push           = 1'b1;
    job_c.kind     = snfcs_pkg::JOB_REJECT;
    job_c.addr     = s3_req_r.addr;
    job_c.data     = s3_req_r.data;
    job_c.flag     = 1'b0;

    if (s3_req_r.cmd == snfcs_pkg::CMD_REPLY) begin
      if (phase_r == PH_POLL) begin
        if (s3_req_r.data[snfcs_pkg::BUSY_BIT]) begin
          job_c.kind = snfcs_pkg::JOB_FILL;
        end else begin
          job_c.kind = snfcs_pkg::JOB_DONE;
          phase_nxt  = run_active_r ? PH_WRITE : PH_IDLE;
        end
      end else if (phase_r == PH_RWAIT || phase_r == PH_RWAIT_LAST) begin
        job_c.kind = snfcs_pkg::JOB_RDATA;
        job_c.flag = (phase_r == PH_RWAIT_LAST);
        if (phase_r == PH_RWAIT_LAST) begin
          run_active_nxt = 1'b0;
          phase_nxt      = PH_IDLE;
        end else begin
          phase_nxt = PH_READ;
        end
      end else begin
        push = 1'b0;  // unsolicited reply
      end
    end else if (phase_r == PH_READ && s3_req_r.cmd == snfcs_pkg::CMD_READ &&
                 !s3_req_r.first) begin
      job_c.kind     = snfcs_pkg::JOB_FILL;
      cur_addr_nxt   = cur_addr_r + 24'd1;
      run_active_nxt = 1'b1;
      phase_nxt      = s3_req_r.last ? PH_RWAIT_LAST : PH_RWAIT;
    end else if (phase_r != PH_IDLE && phase_r <= PH_POLL &&
                 !(phase_r == PH_WRITE && s3_req_r.cmd == snfcs_pkg::CMD_WRITE &&
                   !s3_req_r.first)) begin
      job_c.kind = snfcs_pkg::JOB_REJECT;  // busy or run interrupted
    end else if (s3_req_r.cmd == snfcs_pkg::CMD_ERASE) begin
      job_c.kind     = snfcs_pkg::JOB_ERASE;
      page_open_nxt  = 1'b0;
      run_active_nxt = 1'b0;
      cur_addr_nxt   = s3_req_r.addr;
      phase_nxt      = PH_POLL;
    end else if (s3_req_r.cmd == snfcs_pkg::CMD_WRITE) begin
      job_c.kind   = wb_popen ? snfcs_pkg::JOB_WRITE : snfcs_pkg::JOB_WRITE_HDR;
      job_c.addr   = wb_base;
      job_c.flag   = wb_end;
      cur_addr_nxt = wb_next;
      rem_nxt      = wb_nrem;
      if (wb_end) begin
        page_open_nxt  = 1'b0;
        run_active_nxt = !s3_req_r.last;
        phase_nxt      = PH_POLL;
      end else begin
        page_open_nxt  = 1'b1;
        run_active_nxt = 1'b1;
        phase_nxt      = PH_WRITE;
      end
    end else begin
      // Read from idle: header, address and the first dummy byte
      job_c.kind     = snfcs_pkg::JOB_READ_HDR;
      page_open_nxt  = 1'b0;
      cur_addr_nxt   = s3_req_r.addr + 24'd1;
      run_active_nxt = 1'b1;
      phase_nxt      = s3_req_r.last ? PH_RWAIT_LAST : PH_RWAIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      cur_addr_r   <= '0;
      rem_r        <= '0;
      page_open_r  <= 1'b0;
      run_active_r <= 1'b0;
    end else if (s3_take) begin
      phase_r      <= phase_nxt;
      cur_addr_r   <= cur_addr_nxt;
      rem_r        <= rem_nxt;
      page_open_r  <= page_open_nxt;
      run_active_r <= run_active_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/snfcs_queue.sv -----
// Short job queue between the front and the back end.
// Depends on snfcs_pkg for the job type and depth.
`timescale 1ns / 1ps
`default_nettype none

module snfcs_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire snfcs_pkg::job_t push_job,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output snfcs_pkg::job_t      pop_job
);

  localparam int DEPTH = snfcs_pkg::QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  snfcs_pkg::job_t slot_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/snfcs_back.sv -----
// Back end: steps through each job and issues one result per cycle, unless
// out_ready stalls it, into the output register. Depends on snfcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module snfcs_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            job_valid,
  output logic                 job_ready,
  input  wire snfcs_pkg::job_t job,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output snfcs_pkg::result_t   out_res
);

  snfcs_pkg::job_t    job_r;
  logic [2:0]         step_r;
  logic               busy_r;
  logic               out_v_r;
  snfcs_pkg::result_t out_r;
  snfcs_pkg::result_t res;
  logic               emit, load;

  // Result for one step of a job
  function automatic snfcs_pkg::result_t decode_step(input snfcs_pkg::job_t j,
                                                     input logic [2:0] s);
    snfcs_pkg::result_t r;
    r = '0;
    unique case (j.kind) inside
      snfcs_pkg::JOB_ERASE: begin
        r.spi_valid = 1'b1;
        case (s)
          3'd0: begin r.spi_byte = snfcs_pkg::OP_WREN; r.frame_end = 1'b1; end
          3'd1: r.spi_byte = snfcs_pkg::OP_SE;
          3'd2: r.spi_byte = j.addr[23:16];
          3'd3: r.spi_byte = j.addr[15:8];
          3'd4: begin r.spi_byte = j.addr[7:0]; r.frame_end = 1'b1; end
          3'd5: r.spi_byte = snfcs_pkg::OP_RDSR;
          default: begin
            r.spi_byte     = snfcs_pkg::FILL_BYTE;
            r.reply_wanted = 1'b1;
            r.last_result  = 1'b1;
          end
        endcase
      end
      snfcs_pkg::JOB_WRITE_HDR, snfcs_pkg::JOB_WRITE: begin
        r.spi_valid = 1'b1;
        case (s)
          3'd0: begin r.spi_byte = snfcs_pkg::OP_WREN; r.frame_end = 1'b1; end
          3'd1: r.spi_byte = snfcs_pkg::OP_PP;
          3'd2: r.spi_byte = j.addr[23:16];
          3'd3: r.spi_byte = j.addr[15:8];
          3'd4: r.spi_byte = j.addr[7:0];
          3'd5: begin
            r.spi_byte    = j.data;
            r.frame_end   = j.flag;
            r.last_result = !j.flag;
          end
          3'd6: r.spi_byte = snfcs_pkg::OP_RDSR;
          default: begin
            r.spi_byte     = snfcs_pkg::FILL_BYTE;
            r.reply_wanted = 1'b1;
            r.last_result  = 1'b1;
          end
        endcase
      end
      snfcs_pkg::JOB_READ_HDR: begin
        r.spi_valid = 1'b1;
        case (s)
          3'd0: r.spi_byte = snfcs_pkg::OP_READ;
          3'd1: r.spi_byte = j.addr[23:16];
          3'd2: r.spi_byte = j.addr[15:8];
          3'd3: r.spi_byte = j.addr[7:0];
          default: begin
            r.spi_byte     = snfcs_pkg::FILL_BYTE;
            r.reply_wanted = 1'b1;
            r.last_result  = 1'b1;
          end
        endcase
      end
      snfcs_pkg::JOB_FILL: begin
        r.spi_valid    = 1'b1;
        r.spi_byte     = snfcs_pkg::FILL_BYTE;
        r.reply_wanted = 1'b1;
        r.last_result  = 1'b1;
      end
      snfcs_pkg::JOB_REJECT: begin
        r.rejected    = 1'b1;
        r.last_result = 1'b1;
      end
      snfcs_pkg::JOB_DONE: begin
        r.frame_end   = 1'b1;
        r.done_res    = 1'b1;
        r.last_result = 1'b1;
      end
      snfcs_pkg::JOB_RDATA: begin
        r.read_data   = j.data;
        r.read_valid  = 1'b1;
        r.frame_end   = j.flag;
        r.last_result = 1'b1;
      end
    endcase
    return r;
  endfunction

  assign res       = decode_step(job_r, step_r);
  assign emit      = busy_r && (!out_v_r || out_ready);
  assign load      = job_valid && (!busy_r || (emit && res.last_result));
  assign job_ready = load;
  assign out_valid = out_v_r;
  assign out_res   = out_r;

  // Sequencer control and output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (emit) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
      if (load) begin
        busy_r <= 1'b1;
      end else if (emit && res.last_result) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Job, step and result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= res;
    end
    if (load) begin
      job_r  <= job;
      step_r <= (job.kind == snfcs_pkg::JOB_WRITE) ? snfcs_pkg::STEP_DATA : 3'd0;
    end else if (emit) begin
      step_r <= step_r + 3'd1;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/spi_nor_flash_command_sequencer.sv -----
// SPI NOR flash command sequencer, 24-bit addressing, standard opcodes.
// Usage:
//   in_*  : requests (erase, program byte, read byte) and bytes returned by
//           the SPI link; out_* : SPI bytes to send, framing, read data,
//           done and reject flags, one result per transaction.
//   A request gives 0 to 8 results; out_tlast marks the last of them.
//   Results that carry reply_wanted must have the byte received for them
//   returned as a reply request.
// Path: front offset pipeline, job queue, back-end step and output registers.
// Throughput: the back end issues one result per cycle while out_tready does
//   not stall it; a job gives 1 to 8 results, a full page-program header 8.
//   The front takes one request per cycle into a four-entry job queue while
//   the back end drains it, as long as the queue has room.
// Stall: when out_tready is low the output register holds; the queue fills
//   and in_tready drops once the queue is full and a job waits in the front.
// Reset: rst_n (synchronous, active low) empties the pipeline and queue and
//   returns the flash phase to idle with address zero.
// Depends on snfcs_pkg, snfcs_front, snfcs_queue and snfcs_back.
`timescale 1ns / 1ps
`default_nettype none

module spi_nor_flash_command_sequencer #(
  parameter int PAGE_BYTES = snfcs_pkg::PAGE_BYTES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // address[23:0], data[31:24]
  input  wire logic [snfcs_pkg::IN_DATA_W-1:0]   in_tdata,
  // command[1:0], first[2]
  input  wire logic [snfcs_pkg::IN_USER_W-1:0]   in_tuser,
  input  wire logic                              in_tlast,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // spi_byte[7:0], frame_end[8], reply_wanted[9], read_data[17:10], zero fill
  output logic [snfcs_pkg::OUT_DATA_W-1:0]       out_tdata,
  // spi_valid[0], read_valid[1], done_res[2], rejected[3]
  output logic [snfcs_pkg::OUT_USER_W-1:0]       out_tuser,
  output logic                                   out_tlast
);

  snfcs_pkg::job_t    f_job, q_job;
  logic               f_valid, f_ready, q_valid, q_ready;
  snfcs_pkg::result_t res;

  snfcs_front #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job       (f_job)
  );

  snfcs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_job   (f_job),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_job    (q_job)
  );

  snfcs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job       (q_job),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // Pack the result onto the stream
  assign out_tdata = {6'd0, res.read_data, res.reply_wanted, res.frame_end, res.spi_byte};
  assign out_tuser = {res.rejected, res.done_res, res.read_valid, res.spi_valid};
  assign out_tlast = res.last_result;

endmodule

`default_nettype wire

// ----- rtl/core/snfcs_checker.sv -----
// Port-level checks of the command sequencer, bound to the top level.
// Depends on snfcs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module snfcs_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic [snfcs_pkg::IN_DATA_W-1:0] in_tdata,
  input wire logic [snfcs_pkg::IN_USER_W-1:0] in_tuser,
  input wire logic                            in_tlast,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [snfcs_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic [snfcs_pkg::OUT_USER_W-1:0] out_tuser,
  input wire logic                            out_tlast
);

  logic in_seen;
  assign in_seen = in_tvalid && in_tready && (in_tdata != '0 || in_tuser != '0 || in_tlast);

  // A stalled result holds its payload
  `ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready && !in_seen,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  // Byte fields read zero unless flagged valid
  `ASSERT_IMP(a_zero_fields, clk, rst_n, out_tvalid,
    (out_tuser[0] || out_tdata[7:0] == 8'd0) && (out_tuser[1] || out_tdata[17:10] == 8'd0))

  // A reject stands alone: no SPI byte, no framing, closes the request
  `ASSERT_IMP(a_reject_alone, clk, rst_n, out_tvalid && out_tuser[3],
    out_tlast && !out_tuser[0] && !out_tuser[1] && !out_tuser[2] && !out_tdata[8])

  // Poll completion releases chip select and closes the request
  `ASSERT_IMP(a_done_frame, clk, rst_n, out_tvalid && out_tuser[2],
    out_tlast && out_tdata[8] && !out_tuser[0])

  // Every byte that wants a reply is a dummy byte and ends its request
  `ASSERT_IMP(a_reply_fill, clk, rst_n, out_tvalid && out_tdata[9],
    out_tuser[0] && out_tlast && out_tdata[7:0] == snfcs_pkg::FILL_BYTE)

endmodule

bind spi_nor_flash_command_sequencer snfcs_checker u_snfcs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

// ----- bench/spi_nor_flash_command_sequencer_test.sv -----
// Self-checking bench for the SPI NOR flash command sequencer: a directed table, then
// random erase, program and read runs with status and read replies fed back.
// Depends on snfcs_pkg and spi_nor_flash_command_sequencer.
`timescale 1ns / 1ps

module spi_nor_flash_command_sequencer_test;
  import snfcs_pkg::*;

  localparam int PAGE_SIZE    = PAGE_BYTES_DEF;
  localparam int RANDOM_ITEMS = 385;
  localparam int SETTLE       = 20;
  localparam int CYCLE_LIMIT  = 400000;

  // Flash-side phase of the sequencer as the bench tracks it
  typedef enum logic [2:0] {
    PH_IDLE, PH_WRITE, PH_READ, PH_RWAIT, PH_RWAIT_LAST, PH_POLL
  } flash_phase_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [23:0] addr;
    logic [7:0]  data;
    logic        first;
    logic        last;
    bit          typed;
    result_t     want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;   // address[23:0], data[31:24]
  logic [IN_USER_W-1:0] in_tuser = '0;   // command[1:0], first[2]
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;      // spi_byte[7:0], frame_end[8], reply_wanted[9],
                                         // read_data[17:10], zero fill
  logic [OUT_USER_W-1:0] out_tuser;      // spi_valid[0], read_valid[1], done_res[2],
                                         // rejected[3]
  logic out_tlast;

  spi_nor_flash_command_sequencer #(.PAGE_BYTES(PAGE_SIZE)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #5 clk = ~clk;

  // Bench copy of the flash state and the results still owed
  flash_phase_t fl_phase = PH_IDLE;
  logic [23:0]  fl_addr = '0;
  logic         fl_page_open = 1'b0;
  logic         fl_run = 1'b0;
  result_t      bytes_due[$];

  int errors = 0;
  int cycles = 0;
  int n_requests = 0, n_results = 0, n_rejects = 0, n_done = 0, n_reads = 0;
  int burst_left = 0;
  int run_left = 0;

  function automatic void emit(input logic [7:0] spi_byte, input logic spi_valid,
                               input logic frame_end, input logic reply_wanted,
                               input logic [7:0] read_data, input logic read_valid,
                               input logic done_res, input logic rejected);
    result_t r;
    r.spi_byte     = spi_byte;
    r.spi_valid    = spi_valid;
    r.frame_end    = frame_end;
    r.reply_wanted = reply_wanted;
    r.read_data    = read_data;
    r.read_valid   = read_valid;
    r.done_res     = done_res;
    r.rejected     = rejected;
    r.last_result  = 1'b0;
    bytes_due.push_back(r);
  endfunction

  function automatic void emit_spi(input logic [7:0] b, input logic fe, input logic rw);
    emit(b, 1'b1, fe, rw, 8'h00, 1'b0, 1'b0, 1'b0);
  endfunction

  function automatic void emit_address(input logic [23:0] a, input logic fe_on_low);
    emit_spi(a[23:16], 1'b0, 1'b0);
    emit_spi(a[15:8], 1'b0, 1'b0);
    emit_spi(a[7:0], fe_on_low, 1'b0);
  endfunction

  function automatic void open_status_poll();
    emit_spi(OP_RDSR, 1'b0, 1'b0);
    emit_spi(FILL_BYTE, 1'b0, 1'b1);
    fl_phase = PH_POLL;
  endfunction

  // One program byte; opens the page frame first when needed
  function automatic void program_byte(input logic [7:0] data, input logic last);
    logic [23:0] next;
    logic        close;
    if (!fl_page_open) begin
      emit_spi(OP_WREN, 1'b1, 1'b0);
      emit_spi(OP_PP, 1'b0, 1'b0);
      emit_address(fl_addr, 1'b0);
      fl_page_open = 1'b1;
    end
    next  = fl_addr + 24'd1;
    close = last || ((int'(next) % PAGE_SIZE) == 0);
    emit_spi(data, close, 1'b0);
    fl_addr = next;
    if (close) begin
      fl_page_open = 1'b0;
      fl_run = !last;
      open_status_poll();
    end else begin
      fl_run = 1'b1;
      fl_phase = PH_WRITE;
    end
  endfunction

  function automatic void fetch_byte(input logic last);
    emit_spi(FILL_BYTE, 1'b0, 1'b1);
    fl_addr = fl_addr + 24'd1;
    fl_run = 1'b1;
    fl_phase = last ? PH_RWAIT_LAST : PH_RWAIT;
  endfunction

  // Works out the SPI bytes and flags that one accepted request causes
  function automatic void sequence_bytes(input logic [1:0] cmd, input logic [23:0] addr,
                                         input logic [7:0] data, input logic first,
                                         input logic last);
    int base;
    logic fin;
    base = bytes_due.size();
    if (cmd == CMD_REPLY) begin
      if (fl_phase == PH_POLL) begin
        if (data[BUSY_BIT]) begin
          emit_spi(FILL_BYTE, 1'b0, 1'b1);
        end else begin
          emit(8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0);
          fl_phase = fl_run ? PH_WRITE : PH_IDLE;
        end
      end else if (fl_phase == PH_RWAIT || fl_phase == PH_RWAIT_LAST) begin
        fin = (fl_phase == PH_RWAIT_LAST);
        emit(8'h00, 1'b0, fin, 1'b0, data, 1'b1, 1'b0, 1'b0);
        if (fin) begin
          fl_run = 1'b0;
          fl_phase = PH_IDLE;
        end else begin
          fl_phase = PH_READ;
        end
      end
    end else if (fl_phase == PH_WRITE && cmd == CMD_WRITE && !first) begin
      program_byte(data, last);
    end else if (fl_phase == PH_READ && cmd == CMD_READ && !first) begin
      fetch_byte(last);
    end else if (fl_phase != PH_IDLE) begin
      emit(8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1);
    end else begin
      fl_page_open = 1'b0;
      fl_run = 1'b0;
      fl_addr = addr;
      if (cmd == CMD_ERASE) begin
        emit_spi(OP_WREN, 1'b1, 1'b0);
        emit_spi(OP_SE, 1'b0, 1'b0);
        emit_address(addr, 1'b1);
        open_status_poll();
      end else if (cmd == CMD_WRITE) begin
        program_byte(data, last);
      end else begin
        emit_spi(OP_READ, 1'b0, 1'b0);
        emit_address(addr, 1'b0);
        fetch_byte(last);
      end
    end
    if (bytes_due.size() > base) bytes_due[bytes_due.size() - 1].last_result = 1'b1;
  endfunction

  // Typed first results for the directed table
  function automatic result_t want_wren();
    result_t r;
    r = '0;
    r.spi_byte  = OP_WREN;
    r.spi_valid = 1'b1;
    r.frame_end = 1'b1;
    return r;
  endfunction

  function automatic result_t want_reject();
    result_t r;
    r = '0;
    r.rejected    = 1'b1;
    r.last_result = 1'b1;
    return r;
  endfunction

  function automatic result_t want_done();
    result_t r;
    r = '0;
    r.frame_end   = 1'b1;
    r.done_res    = 1'b1;
    r.last_result = 1'b1;
    return r;
  endfunction

  function automatic result_t want_read(input logic [7:0] d, input logic fe);
    result_t r;
    r = '0;
    r.read_data   = d;
    r.read_valid  = 1'b1;
    r.frame_end   = fe;
    r.last_result = 1'b1;
    return r;
  endfunction

  // Holds valid until the transaction is taken, then books its results
  task automatic send_req(input logic [1:0] cmd, input logic [23:0] addr,
                          input logic [7:0] data, input logic first, input logic last,
                          input bit typed, input result_t want, output int n);
    int base;
    in_tvalid <= 1'b1;
    in_tdata  <= {data, addr};
    in_tuser  <= {first, cmd};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    base = bytes_due.size();
    sequence_bytes(cmd, addr, data, first, last);
    n = bytes_due.size() - base;
    if (typed && n > 0) bytes_due[base] = want;
    n_requests++;
  endtask

  // Sender bursts with random gaps in between
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // A reply only comes back once the byte it answers has gone out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (bytes_due.size() != 0);
    @(posedge clk);
  endtask

  function automatic logic [23:0] pick_address();
    logic [23:0] a;
    a = 24'($urandom);
    case ($urandom_range(0, 3))
      1: a[7:0] = 8'hFF - 8'($urandom_range(0, 7));
      2: a = 24'hFFFFFF - 24'($urandom_range(0, 7));
      default: ;
    endcase
    return a;
  endfunction

  // Receiver: ready pattern switches between modes after runs of random length
  int rx_mode = 0, rx_left = 0;
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(24, 160);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 1) == 1);
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= ($urandom_range(0, 11) == 0);
    endcase
  end

  // Text form of one result for the mismatch report
  function automatic string show(input result_t r);
    return $sformatf("byte=%h v=%b fe=%b rw=%b rd=%h rv=%b dn=%b rj=%b last=%b",
                     r.spi_byte, r.spi_valid, r.frame_end, r.reply_wanted, r.read_data,
                     r.read_valid, r.done_res, r.rejected, r.last_result);
  endfunction

  // Result checker: each transaction against the oldest owed result
  always @(posedge clk) begin
    result_t seen, due;
    if (rst_n && out_tvalid && out_tready) begin
      seen.spi_byte     = out_tdata[7:0];
      seen.frame_end    = out_tdata[8];
      seen.reply_wanted = out_tdata[9];
      seen.read_data    = out_tdata[17:10];
      seen.spi_valid    = out_tuser[0];
      seen.read_valid   = out_tuser[1];
      seen.done_res     = out_tuser[2];
      seen.rejected     = out_tuser[3];
      seen.last_result  = out_tlast;
      if (out_tdata[OUT_DATA_W-1:18] !== '0) begin
        errors++;
        $display("%0t: fill bits expected 0 actual %h", $time, out_tdata[OUT_DATA_W-1:18]);
      end
      if (bytes_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %s", $time, show(seen));
      end else begin
        due = bytes_due.pop_front();
        n_results++;
        if (due.rejected) n_rejects++;
        if (due.done_res) n_done++;
        if (due.read_valid) n_reads++;
        if (seen !== due) begin
          errors++;
          $display("%0t: mismatch expected %s", $time, show(due));
          $display("%0t:          actual   %s", $time, show(seen));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, bytes_due.size());
      $display("spi_nor_flash_command_sequencer_test: done, errors");
      $finish;
    end
  end

  stim_row_t directed[$];

  function automatic void add_row(input logic [1:0] cmd, input logic [23:0] addr,
                                  input logic [7:0] data, input logic first,
                                  input logic last, input bit typed, input result_t want);
    stim_row_t row;
    row.cmd   = cmd;
    row.addr  = addr;
    row.data  = data;
    row.first = first;
    row.last  = last;
    row.typed = typed;
    row.want  = want;
    directed.push_back(row);
  endfunction

  initial begin
    int i, n, roll, random_done;
    logic [1:0]  cmd;
    logic [23:0] addr;
    logic [7:0]  data;
    logic        first, last, reply_due, cont;

    // Directed table: extremes, every command, every special case
    add_row(CMD_ERASE, 24'h000000, 8'h00, 1'b0, 1'b0, 1, want_wren());
    add_row(CMD_WRITE, 24'hFFFFFF, 8'hFF, 1'b1, 1'b1, 1, want_reject());   // busy polling
    add_row(CMD_REPLY, 24'h000000, 8'hFF, 1'b0, 1'b0, 0, '0);             // still busy
    add_row(CMD_REPLY, 24'hFFFFFF, 8'h01, 1'b1, 1'b1, 0, '0);
    add_row(CMD_REPLY, 24'h000000, 8'hFE, 1'b0, 1'b0, 1, want_done());
    add_row(CMD_ERASE, 24'hFFFFFF, 8'hFF, 1'b1, 1'b1, 0, '0);
    add_row(CMD_REPLY, 24'h000000, 8'h00, 1'b0, 1'b0, 1, want_done());
    add_row(CMD_WRITE, 24'hFFFFFE, 8'h00, 1'b1, 1'b0, 1, want_wren());
    add_row(CMD_WRITE, 24'h000000, 8'hFF, 1'b0, 1'b0, 0, '0);             // wrap closes page
    add_row(CMD_READ,  24'h000000, 8'h00, 1'b1, 1'b1, 1, want_reject());
    add_row(CMD_REPLY, 24'h000000, 8'h00, 1'b0, 1'b0, 1, want_done());
    add_row(CMD_ERASE, 24'h123456, 8'h00, 1'b0, 1'b0, 1, want_reject());   // inside a run
    add_row(CMD_WRITE, 24'h000000, 8'h11, 1'b1, 1'b0, 1, want_reject());
    add_row(CMD_WRITE, 24'h000000, 8'h5A, 1'b0, 1'b1, 0, '0);             // reopens at 0
    add_row(CMD_REPLY, 24'h000000, 8'h00, 1'b0, 1'b0, 1, want_done());
    add_row(CMD_WRITE, 24'h0000FF, 8'hA5, 1'b0, 1'b1, 0, '0);             // run without first
    add_row(CMD_REPLY, 24'h000000, 8'h00, 1'b0, 1'b0, 1, want_done());
    add_row(CMD_REPLY, 24'h000000, 8'h00, 1'b0, 1'b0, 0, '0);             // nobody waiting
    add_row(CMD_READ,  24'h123456, 8'h00, 1'b1, 1'b0, 0, '0);
    add_row(CMD_WRITE, 24'hABCDEF, 8'h00, 1'b0, 1'b0, 1, want_reject());   // awaiting reply
    add_row(CMD_REPLY, 24'h000000, 8'h00, 1'b0, 1'b0, 1, want_read(8'h00, 1'b0));
    add_row(CMD_READ,  24'h000000, 8'h00, 1'b0, 1'b1, 0, '0);
    add_row(CMD_REPLY, 24'h000000, 8'hFF, 1'b0, 1'b0, 1, want_read(8'hFF, 1'b1));
    add_row(CMD_READ,  24'hFFFFFF, 8'h00, 1'b0, 1'b1, 0, '0);             // wraps to 0
    add_row(CMD_REPLY, 24'h000000, 8'hC3, 1'b0, 1'b0, 0, '0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < directed.size(); i++) begin
      pace();
      if (directed[i].cmd == CMD_REPLY) wait_drained();
      send_req(directed[i].cmd, directed[i].addr, directed[i].data, directed[i].first,
               directed[i].last, directed[i].typed, directed[i].want, n);
    end

    // Random part: mostly well-formed runs, with noise and stray replies mixed in
    random_done = 0;
    while (random_done < RANDOM_ITEMS) begin
      roll      = $urandom_range(0, 99);
      addr      = 24'($urandom);
      data      = 8'($urandom);
      first     = 1'($urandom);
      last      = 1'($urandom);
      cmd       = 2'($urandom_range(0, 2));
      reply_due = 1'b0;
      cont      = 1'b0;
      case (fl_phase)
        PH_IDLE: begin
          if (roll < 5) begin
            cmd = CMD_REPLY;
          end else if (roll < 25) begin
            cmd  = CMD_ERASE;
            addr = pick_address();
          end else begin
            cmd      = (roll < 65) ? CMD_WRITE : CMD_READ;
            addr     = pick_address();
            run_left = (cmd == CMD_READ) ? $urandom_range(1, 6)
                     : (($urandom_range(0, 9) == 0) ? $urandom_range(16, 40)
                                                    : $urandom_range(1, 8));
            first    = ($urandom_range(0, 9) != 0);
            cont     = 1'b1;
          end
        end
        PH_WRITE, PH_READ: begin
          if (roll < 4) begin
            cmd = CMD_REPLY;
          end else if (roll < 12) begin
            // a request that breaks into the run
            if (cmd == ((fl_phase == PH_WRITE) ? CMD_WRITE : CMD_READ)) first = 1'b1;
          end else begin
            cmd   = (fl_phase == PH_WRITE) ? CMD_WRITE : CMD_READ;
            first = 1'b0;
            cont  = 1'b1;
          end
        end
        PH_POLL: begin
          if (roll >= 15) begin
            cmd       = CMD_REPLY;
            data[BUSY_BIT] = ($urandom_range(0, 99) < 40);
            reply_due = 1'b1;
          end
        end
        default: begin
          if (roll >= 10) begin
            cmd       = CMD_REPLY;
            reply_due = 1'b1;
          end
        end
      endcase
      if (cont) begin
        last = (run_left <= 1);
        if (run_left > 0) run_left--;
      end
      pace();
      if (reply_due) wait_drained();
      send_req(cmd, addr, data, first, last, 0, '0, n);
      if (n > 0) random_done++;
    end

    // Let the pipeline empty, then watch for stray results
    in_tvalid <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Sent %0d requests (%0d from the table), checked %0d results:", n_requests,
             directed.size(), n_results);
    $display("  %0d rejected, %0d erase/program completions, %0d read bytes returned",
             n_rejects, n_done, n_reads);
    if (errors == 0) begin
      $display("spi_nor_flash_command_sequencer_test: done, clean");
    end else begin
      $display("spi_nor_flash_command_sequencer_test: done, errors");
    end
    $finish;
  end

endmodule
